FILE: rtl/mdr_pkg.sv
package mdr_pkg;

	// field widths
	localparam int DELTA_W = 32;
	localparam int CH_W    = 4;
	localparam int CMD_W   = 4;
	localparam int VAL_W   = 8;
	localparam int LIMIT_W = 13;

	// packed port widths
	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 4;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_TUSER_W = 3;

	localparam int MAX_CHANNELS      = 16;
	localparam int CHANNEL_COUNT_DEF = 16;
	localparam int BUFFER_BYTES_DEF  = 4096;
	localparam int EVENT_BYTES       = 12;
	localparam int CAP_SLACK         = 11;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4000;

	// status high nibbles
	localparam logic [CMD_W-1:0] CMD_NOTE_OFF     = 4'h8;
	localparam logic [CMD_W-1:0] CMD_NOTE_ON      = 4'h9;
	localparam logic [CMD_W-1:0] CMD_POLY_PRESS   = 4'hA;
	localparam logic [CMD_W-1:0] CMD_CONTROLLER   = 4'hB;
	localparam logic [CMD_W-1:0] CMD_PROGRAM      = 4'hC;
	localparam logic [CMD_W-1:0] CMD_CHAN_PRESS   = 4'hD;
	localparam logic [CMD_W-1:0] CMD_PITCH_WHEEL  = 4'hE;

	typedef enum logic [1:0] {
		OUT_WRITTEN = 2'd0,
		OUT_LATE    = 2'd1,
		OUT_INVALID = 2'd2
	} outcome_t;

	// channel time write from the compute stage
	typedef struct packed {
		logic                en;
		logic [CH_W-1:0]     idx;
		logic [DELTA_W-1:0]  evt_time;
	} chan_wr_t;

endpackage

FILE: rtl/mdr_chan_times.sv
module mdr_chan_times #(
	parameter int CHANNEL_COUNT = mdr_pkg::CHANNEL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mdr_pkg::CH_W-1:0]      rd_ch,
	input  mdr_pkg::chan_wr_t             wr,
	output logic [mdr_pkg::DELTA_W-1:0]   rd_time,
	output logic [mdr_pkg::DELTA_W-1:0]   latest
);
	import mdr_pkg::*;

	localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	logic [DELTA_W-1:0] ct_q [CHANNEL_COUNT];
	logic [DELTA_W-1:0] leaf [MAX_CHANNELS];
	logic [DELTA_W-1:0] lvl1 [MAX_CHANNELS/2];
	logic [DELTA_W-1:0] lvl2 [MAX_CHANNELS/4];
	logic [DELTA_W-1:0] lvl3 [MAX_CHANNELS/8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) ct_q[i] <= '0;
		end else begin
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				if (wr.en && (wr.idx == CH_W'(i))) ct_q[i] <= wr.evt_time;
			end
		end
	end

	assign rd_time = ct_q[rd_ch[IDX_W-1:0]];

	// pad unused leaves with zero, which never wins the max
	for (genvar gi = 0; gi < MAX_CHANNELS; gi++) begin : g_leaf
		if (gi < CHANNEL_COUNT) begin : g_used
			assign leaf[gi] = ct_q[gi];
		end else begin : g_pad
			assign leaf[gi] = '0;
		end
	end

	// four-level unsigned max tree
	always_comb begin
		for (int i = 0; i < MAX_CHANNELS/2; i++)
			lvl1[i] = (leaf[2*i] > leaf[2*i+1]) ? leaf[2*i] : leaf[2*i+1];
		for (int i = 0; i < MAX_CHANNELS/4; i++)
			lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
		for (int i = 0; i < MAX_CHANNELS/8; i++)
			lvl3[i] = (lvl2[2*i] > lvl2[2*i+1]) ? lvl2[2*i] : lvl2[2*i+1];
		latest = (lvl3[0] > lvl3[1]) ? lvl3[0] : lvl3[1];
	end

endmodule

FILE: rtl/midi_multichannel_delta_retimer_top.sv
// A word accepted on s_ passes through the input register and the result register to m_.
// Throughput: one word per cycle unless m_tready stalls; the compute stage holds the
// channel-time add, the sixteen-way max tree over channel times and the late compare.
// Reset (arst_n low, asynchronous): all channel times zero, byte count zero,
// fill limit 4000, first buffer used is buffer 0, both pipeline stages empty.
module midi_multichannel_delta_retimer_top #(
	parameter int CHANNEL_COUNT = mdr_pkg::CHANNEL_COUNT_DEF,
	parameter int BUFFER_BYTES  = mdr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input event words
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// time_delta[31:0], channel[35:32], first_value[43:36], second_value[51:44], zero pad
	input  logic [mdr_pkg::IN_TDATA_W-1:0]    s_tdata,
	// command_nibble[3:0]
	input  logic [mdr_pkg::IN_TUSER_W-1:0]    s_tuser,
	// result words
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// global_delta[31:0], status_byte[39:32], data_one[47:40], data_two[55:48]
	output logic [mdr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// outcome[1:0], buffer_index[2]
	output logic [mdr_pkg::OUT_TUSER_W-1:0]   m_tuser,
	// buffer_closed
	output logic                              m_tlast,
	// fill limit register
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mdr_pkg::LIMIT_W-1:0]       cfg_data
);
	import mdr_pkg::*;

	// byte counter must hold up to BUFFER_BYTES; compare in the wider of counter and limit
	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	// ---------------- input register ----------------
	logic                 valid_s1;
	logic [DELTA_W-1:0]   delta_s1;
	logic [CH_W-1:0]      ch_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [VAL_W-1:0]     v1_s1;
	logic [VAL_W-1:0]     v2_s1;

	logic                 out_valid_q;
	logic                 advance;

	// advance the stage when the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			delta_s1 <= s_tdata[31:0];
			ch_s1    <= s_tdata[35:32];
			v1_s1    <= s_tdata[43:36];
			v2_s1    <= s_tdata[51:44];
			cmd_s1   <= s_tuser[3:0];
		end
	end

	// ---------------- configuration ----------------
	logic [LIMIT_W-1:0] limit_q;

	// user must change configuration only while idle (unchecked); cfg_ready is always 1
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// ---------------- channel times ----------------
	chan_wr_t            chan_wr;
	logic [DELTA_W-1:0]  rd_time;
	logic [DELTA_W-1:0]  latest;

	mdr_chan_times #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_chan_times (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_ch   (ch_s1),
		.wr      (chan_wr),
		.rd_time (rd_time),
		.latest  (latest)
	);

	// ---------------- compute stage ----------------
	logic                 in_range;
	logic [DELTA_W-1:0]   evt_time;
	logic                 late;
	logic                 cmd_ok;
	logic                 written;
	logic [VAL_W-1:0]     d1;
	logic [VAL_W-1:0]     d2;

	// buffer bookkeeping state
	logic                 active_q;
	logic                 pending_q;
	logic [CNT_W-1:0]     bytes_q;
	logic                 cur_buf;
	logic [CNT_W-1:0]     cur_bytes;
	logic [CNT_W-1:0]     sum;
	logic [CMP_W-1:0]     cap;
	logic [CMP_W-1:0]     limit_ext;
	logic [CMP_W-1:0]     eff_limit;
	logic                 close;

	outcome_t             outcome;
	logic [DELTA_W-1:0]   gdelta;
	logic [7:0]           status;

	assign in_range = {1'b0, ch_s1} < (CH_W+1)'(CHANNEL_COUNT);
	assign evt_time = rd_time + delta_s1;
	assign late     = evt_time < latest;
	assign cmd_ok   = (cmd_s1 >= CMD_NOTE_OFF) && (cmd_s1 <= CMD_PITCH_WHEEL);
	assign written  = in_range && !late && cmd_ok;

	// data bytes per command; pitch wheel data is sent as zero
	always_comb begin
		unique case (cmd_s1)
			CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_PRESS, CMD_CONTROLLER: begin
				d1 = v1_s1;
				d2 = v2_s1;
			end
			CMD_PROGRAM, CMD_CHAN_PRESS: begin
				d1 = v1_s1;
				d2 = '0;
			end
			default: begin
				d1 = '0;
				d2 = '0;
			end
		endcase
	end

	// a pending open flips the buffer and restarts the count before this word
	assign cur_buf   = pending_q ? ~active_q : active_q;
	assign cur_bytes = pending_q ? '0 : bytes_q;
	assign sum       = cur_bytes + CNT_W'(EVENT_BYTES);

	// clamp the limit so a word never runs past the end of a buffer
	assign cap       = CMP_W'(BUFFER_BYTES - CAP_SLACK);
	assign limit_ext = CMP_W'(limit_q);
	assign eff_limit = (limit_ext < cap) ? limit_ext : cap;
	assign close     = written && (CMP_W'(sum) >= eff_limit);

	always_comb begin
		priority if (!in_range) outcome = OUT_INVALID;
		else if (late)          outcome = OUT_LATE;
		else if (!cmd_ok)       outcome = OUT_INVALID;
		else                    outcome = OUT_WRITTEN;
	end

	assign gdelta = (in_range && !late) ? (evt_time - latest) : '0;
	// a late word carries no status byte
	assign status = (in_range && late) ? 8'h00 : {cmd_s1, ch_s1};

	// update the channel time for every in-range word, late or invalid too
	assign chan_wr.en       = advance && in_range;
	assign chan_wr.idx      = ch_s1;
	assign chan_wr.evt_time = evt_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b1;
			pending_q <= 1'b1;
			bytes_q   <= '0;
		end else if (advance) begin
			active_q  <= cur_buf;
			pending_q <= close;
			bytes_q   <= written ? sum : cur_bytes;
		end
	end

	// ---------------- result register ----------------
	outcome_t             outcome_q;
	logic [DELTA_W-1:0]   gdelta_q;
	logic [7:0]           status_q;
	logic [VAL_W-1:0]     d1_q;
	logic [VAL_W-1:0]     d2_q;
	logic                 closed_q;
	logic                 buf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome_q <= outcome;
			gdelta_q  <= gdelta;
			status_q  <= status;
			d1_q      <= written ? d1 : '0;
			d2_q      <= written ? d2 : '0;
			closed_q  <= close;
			buf_q     <= cur_buf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {d2_q, d1_q, status_q, gdelta_q};
	assign m_tuser  = {buf_q, outcome_q};
	assign m_tlast  = closed_q;

endmodule

FILE: rtl/mdr_checker.sv
module mdr_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [mdr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic [mdr_pkg::OUT_TUSER_W-1:0]   m_tuser,
	input  logic                              m_tlast
);
	import mdr_pkg::*;

	logic take;
	logic last_buf_q;
	logic flip_q;

	assign take = m_tvalid && m_tready;

	// track the buffer a taken word should land in; start as if buffer 1 just closed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_buf_q <= 1'b1;
			flip_q     <= 1'b1;
		end else if (take) begin
			last_buf_q <= m_tuser[2];
			flip_q     <= m_tlast;
		end
	end

	a_buf_seq: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (m_tuser[2] == (last_buf_q ^ flip_q)))
		else $error("buffer index out of sequence");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] != 2'd3))
		else $error("undefined outcome code");

	a_close_written: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser[1:0] == OUT_WRITTEN))
		else $error("buffer closed by a word that was not written");

	a_late_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] == OUT_LATE)) |-> ((m_tdata == '0) && !m_tlast))
		else $error("late word carries data");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result word changed while stalled");

endmodule

bind midi_multichannel_delta_retimer_top mdr_checker u_mdr_checker (.*);

FILE: tb/sv/testbench.sv
module testbench;
	import mdr_pkg::*;

	// Command nibbles outside the channel-voice range; the block must flag these as invalid.
	localparam logic [CMD_W-1:0] CMD_LOWEST      = 4'h0;
	localparam logic [CMD_W-1:0] CMD_BELOW_NOTES = 4'h7;
	localparam logic [CMD_W-1:0] CMD_SYSTEM      = 4'hF;

	// The write that closes a buffer may never run past its end.
	localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(BUFFER_BYTES_DEF - CAP_SLACK);
	localparam int LONG_HOLD   = 200;   // receiver hold-off, long enough to back up the pipe
	localparam int STALL_LIMIT = 2000;  // cycles without any handshake before giving up
	localparam int PHASES      = 7;

	typedef struct packed {
		logic [DELTA_W-1:0] delta;
		logic [CH_W-1:0]    ch;
		logic [CMD_W-1:0]   cmd;
		logic [VAL_W-1:0]   v1;
		logic [VAL_W-1:0]   v2;
	} midi_event_t;

	typedef struct packed {
		outcome_t           outcome;
		logic [DELTA_W-1:0] gdelta;
		logic [7:0]         status;
		logic [7:0]         d1;
		logic [7:0]         d2;
		logic               closed;
		logic               buf_idx;
	} retimed_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [IN_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	midi_multichannel_delta_retimer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block: absolute time per channel, byte count, current buffer.
	logic [DELTA_W-1:0] chan_clock [MAX_CHANNELS];
	logic [LIMIT_W-1:0] bytes_used = '0;
	logic               active_buf = 1'b1;
	logic               reopen_due = 1'b1;  // flip to the other buffer on the next event
	logic [LIMIT_W-1:0] fill_limit = LIMIT_RESET;

	// Stimulus side: events waiting to be offered, and a plan of channel times used to
	// steer random deltas around the latest time.
	midi_event_t        pending_events [$];
	midi_event_t        in_flight;
	logic [DELTA_W-1:0] plan_clock [MAX_CHANNELS];
	retimed_word_t      due_retimed_words [$];

	bit sender_idle = 1'b0;
	bit sink_idle = 1'b0;
	bit hold_trigger = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int sink_stall = 0;
	int send_gap = 0;
	int idle_cycles = 0;

	int events_taken = 0;
	int mismatches = 0;
	int written_seen = 0;
	int late_seen = 0;
	int invalid_seen = 0;
	int closes_seen = 0;

	int phase_items [PHASES];
	int phase_on_time [PHASES];
	bit phase_idle [PHASES];
	logic [LIMIT_W-1:0] phase_limit [PHASES];

	initial begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			chan_clock[c] = '0;
			plan_clock[c] = '0;
		end
	end

	// Mostly back-to-back, now and then a short pause, rarely a long one.
	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return 0;
		else if (roll < 95)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 8);
	endfunction

	// Re-time one event against the latest time of all channels, and book its bytes.
	function automatic retimed_word_t retime_event(midi_event_t ev);
		retimed_word_t r;
		logic [DELTA_W-1:0] latest;
		logic [DELTA_W-1:0] evt_time;
		logic [LIMIT_W-1:0] sum;
		logic [LIMIT_W-1:0] lim;
		if (reopen_due) begin
			active_buf = ~active_buf;
			bytes_used = '0;
			reopen_due = 1'b0;
		end
		r = '0;
		r.outcome = OUT_WRITTEN;
		r.status = {ev.cmd, ev.ch};
		r.buf_idx = active_buf;
		// every 4-bit channel exists with sixteen channels, so no out-of-range case
		latest = '0;
		for (int c = 0; c < MAX_CHANNELS; c++)
			if (chan_clock[c] > latest)
				latest = chan_clock[c];
		evt_time = chan_clock[ev.ch] + ev.delta;
		chan_clock[ev.ch] = evt_time;
		if (evt_time < latest) begin
			// late: channel time moves, but nothing else is reported
			r.outcome = OUT_LATE;
			r.status = '0;
			return r;
		end
		r.gdelta = evt_time - latest;
		if (ev.cmd < CMD_NOTE_OFF || ev.cmd > CMD_PITCH_WHEEL) begin
			r.outcome = OUT_INVALID;
			return r;
		end
		if (ev.cmd <= CMD_CONTROLLER) begin
			r.d1 = ev.v1;
			r.d2 = ev.v2;
		end else if (ev.cmd <= CMD_CHAN_PRESS) begin
			r.d1 = ev.v1;
		end
		lim = (fill_limit < LIMIT_CAP) ? fill_limit : LIMIT_CAP;
		sum = bytes_used + LIMIT_W'(EVENT_BYTES);
		if (sum >= lim) begin
			r.closed = 1'b1;
			reopen_due = 1'b1;
		end
		bytes_used = sum;
		return r;
	endfunction

	// Sender: take the next event from the pending queue, hold it until accepted,
	// and predict its word at the edge where it is taken.
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			fill_limit = cfg_data;
		if (s_tvalid && s_tready) begin
			due_retimed_words.push_back(retime_event(in_flight));
			events_taken++;
		end
		if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_events.size() > 0) begin
				in_flight = pending_events.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, in_flight.v2, in_flight.v1, in_flight.ch, in_flight.delta};
				s_tuser <= in_flight.cmd;
				send_gap = sender_idle ? idle_gap() : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: check each word against the oldest prediction, then decide whether to
	// stall next cycle. A toggle of hold_trigger starts the long hold-off.
	always @(posedge clk) begin : sink
		retimed_word_t got;
		retimed_word_t want;
		int g;
		if (m_tvalid && m_tready) begin
			got.outcome = outcome_t'(m_tuser[1:0]);
			got.buf_idx = m_tuser[2];
			got.gdelta = m_tdata[31:0];
			got.status = m_tdata[39:32];
			got.d1 = m_tdata[47:40];
			got.d2 = m_tdata[55:48];
			got.closed = m_tlast;
			if (due_retimed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: outcome %0d delta %h status %h data %h %h",
						got.outcome, got.gdelta, got.status, got.d1, got.d2);
			end else begin
				want = due_retimed_words.pop_front();
				case (want.outcome)
					OUT_WRITTEN: written_seen++;
					OUT_LATE:    late_seen++;
					default:     invalid_seen++;
				endcase
				if (want.closed)
					closes_seen++;
				if (got.outcome !== want.outcome || got.gdelta !== want.gdelta ||
						got.status !== want.status || got.d1 !== want.d1 ||
						got.d2 !== want.d2 || got.closed !== want.closed ||
						got.buf_idx !== want.buf_idx) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: expected outcome %0d delta %h status %h data %h %h last %b buf %b",
							$realtime, want.outcome, want.gdelta, want.status, want.d1, want.d2,
							want.closed, want.buf_idx);
						$display("                  got outcome %0d delta %h status %h data %h %h last %b buf %b",
							got.outcome, got.gdelta, got.status, got.d1, got.d2,
							got.closed, got.buf_idx);
					end
				end
			end
		end
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= 1'b0;
		end else begin
			g = sink_idle ? idle_gap() : 0;
			if (g == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				sink_stall <= g - 1;
			end
		end
	end

	// Watchdog: abandon the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Queue one event and advance the planned time of its channel.
	task automatic queue_event(input logic [DELTA_W-1:0] delta, input logic [CH_W-1:0] ch,
			input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] v1,
			input logic [VAL_W-1:0] v2);
		midi_event_t ev;
		ev.delta = delta;
		ev.ch = ch;
		ev.cmd = cmd;
		ev.v1 = v1;
		ev.v2 = v2;
		plan_clock[ch] = plan_clock[ch] + delta;
		pending_events.push_back(ev);
	endtask

	// Mostly on-time events landing just after the latest time; the rest split between
	// deliberately late ones and wholly random deltas (big jumps, wrap-around).
	task automatic queue_random_event(input int on_time_pct);
		logic [DELTA_W-1:0] latest;
		logic [DELTA_W-1:0] lag;
		logic [DELTA_W-1:0] delta;
		logic [CH_W-1:0] ch;
		logic [CMD_W-1:0] cmd;
		int roll;
		int pick;
		latest = '0;
		for (int c = 0; c < MAX_CHANNELS; c++)
			if (plan_clock[c] > latest)
				latest = plan_clock[c];
		ch = CH_W'($urandom_range(MAX_CHANNELS - 1));
		lag = latest - plan_clock[ch];
		roll = $urandom_range(99);
		if (roll < on_time_pct)
			delta = lag + (($urandom_range(3) == 0) ? 0 : $urandom_range(500));
		else if (roll < on_time_pct + (100 - on_time_pct) / 2 && lag != 0)
			delta = $urandom_range(lag - 1);
		else
			delta = $urandom();
		if ($urandom_range(99) < 88) begin
			cmd = CMD_W'($urandom_range(CMD_PITCH_WHEEL, CMD_NOTE_OFF));
		end else begin
			pick = $urandom_range(8);
			cmd = (pick == 8) ? CMD_SYSTEM : CMD_W'(pick);
		end
		queue_event(delta, ch, cmd, VAL_W'($urandom()), VAL_W'($urandom()));
	endtask

	// Wait for every queued event to be taken and every predicted word to arrive,
	// then let the pipe settle before touching the register.
	task automatic wait_for_drain();
		while (pending_events.size() > 0 || s_tvalid || due_retimed_words.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_fill_limit(input logic [LIMIT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		phase_limit   = '{13'd12, 13'd0, 13'd100, 13'd8191, 13'd4096, 13'd37, 13'd24};
		phase_items   = '{90, 50, 140, 300, 200, 90, 60};
		phase_on_time = '{70, 70, 70, 95, 95, 60, 70};
		phase_idle    = '{1, 0, 1, 1, 0, 1, 1};

		// hold reset low from time zero, then release it on a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset fill limit.
		sender_idle = 1'b1;
		sink_idle = 1'b1;
		queue_event(32'd0, 4'd0, CMD_NOTE_ON, 8'h00, 8'h00);
		queue_event(32'hFFFF_FFFF, 4'd15, CMD_NOTE_OFF, 8'hFF, 8'hFF);
		// behind the latest time: dropped
		queue_event(32'd5, 4'd1, CMD_NOTE_OFF, 8'h7F, 8'h80);
		// channel time wraps round to zero: dropped as well
		queue_event(32'd1, 4'd15, CMD_NOTE_ON, 8'h01, 8'h02);
		// lands exactly on the latest time: zero delta
		queue_event(32'd5, 4'd2, CMD_POLY_PRESS, 8'hAA, 8'h55);
		queue_event(32'd10, 4'd3, CMD_CONTROLLER, 8'h55, 8'hAA);
		queue_event(32'd0, 4'd3, CMD_PROGRAM, 8'h80, 8'h7F);
		queue_event(32'd0, 4'd3, CMD_CHAN_PRESS, 8'hFF, 8'hFF);
		queue_event(32'd0, 4'd3, CMD_PITCH_WHEEL, 8'hFF, 8'hFF);
		// invalid nibbles still move the channel time
		queue_event(32'd20, 4'd4, CMD_LOWEST, 8'h12, 8'h34);
		queue_event(32'd0, 4'd4, CMD_BELOW_NOTES, 8'hFF, 8'hFF);
		queue_event(32'd0, 4'd4, CMD_SYSTEM, 8'hFF, 8'hFF);
		// invalid and late together reports late
		queue_event(32'd1, 4'd6, CMD_SYSTEM, 8'h00, 8'hFF);
		queue_event(32'd100, 4'd7, CMD_NOTE_ON, 8'h3C, 8'h64);
		queue_event(32'h8000_0000, 4'd8, CMD_NOTE_ON, 8'h3C, 8'h00);
		queue_event(32'h7FFF_FFFF, 4'd8, CMD_NOTE_OFF, 8'h3C, 8'h40);
		// bring channels 9 to 14 up to the top of the time range
		for (int c = 9; c < 15; c++)
			queue_event(32'hFFFF_FFFF, CH_W'(c), CMD_CONTROLLER, VAL_W'(c), 8'h7F);
		wait_for_drain();

		// Random phases, each under its own fill limit; the byte count carries over.
		for (int p = 0; p < PHASES; p++) begin
			write_fill_limit(phase_limit[p]);
			@(negedge clk);
			sender_idle = phase_idle[p];
			sink_idle = phase_idle[p];
			for (int n = 0; n < phase_items[p]; n++)
				queue_random_event(phase_on_time[p]);
			// hold the receiver off while the sender keeps offering words
			if (p == 2)
				hold_trigger = ~hold_trigger;
			wait_for_drain();
		end

		$display("retimed %0d events: %0d written, %0d late, %0d invalid, %0d buffer closes",
			events_taken, written_seen, late_seen, invalid_seen, closes_seen);
		$display("fill limits from 0 to 8191 with one long receiver hold-off; %0d mismatches",
			mismatches);
		if (mismatches == 0 && due_retimed_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: midi_multichannel_delta_retimer_top.f
rtl/mdr_pkg.sv
rtl/mdr_chan_times.sv
rtl/midi_multichannel_delta_retimer_top.sv
rtl/mdr_checker.sv
tb/sv/testbench.sv
